// File: rtl/core/wnm_pkg.sv
// Shared types, constants and helpers of the wildcard name matcher.
package wnm_pkg;

    localparam int PATTERN_MAX = 31;
    localparam int NUM_POS     = PATTERN_MAX + 1;
    localparam int POS_W       = 5;
    localparam int NUM_WORDS   = 4;
    localparam int DATA_W      = 64;
    localparam int ADDR_W      = 6;
    localparam int REG_IDX_W   = 3;

    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_ANY  = 8'h3F;

    localparam logic [REG_IDX_W-1:0] REG_PAT_LOW      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAT_MID_LOW  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PAT_MID_HIGH = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PAT_HIGH     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LENGTH       = 3'd4;

    typedef logic [NUM_POS-1:0][7:0] pattern_t;

    // Carries passed from one position cell to the next.
    typedef struct packed {
        logic hit;      // previous position consumed the current character
        logic step;     // star closure of the post-step vector
        logic start;    // star closure of the start vector
        logic refresh;  // star closure of the stored vector
    } link_t;

    typedef struct packed {
        logic refresh;
        logic accept;
        logic last;
    } ctrl_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/wildcard_name_matcher.sv
// Top level of the wildcard name matcher: config port, cell row and result register.
//
//  channel   | direction | payload                          | request accepted when
//  ----------+-----------+----------------------------------+----------------------------
//  s_ stream | in        | tdata: name_char, tlast: end     | s_tvalid & s_tready
//  m_ stream | out       | tdata: matched, tlast: name_done | m_tvalid & m_tready
//  APB       | in        | pattern words and length         | psel & penable & pwrite
//
// Rate: one name character per clock while s_tready is high; each request
// yields its verdict on m_ in the next cycle, from the result register. The
// rate is set by the row of 32 position cells, whose next live bits are all
// formed combinationally through a ripple of star-closure links, cell to cell.
// Reset: synchronous, active low; pattern resets to a single star of length 1.
// After reset and after every register write, s_tready drops for one cycle
// while the cells re-close their live bits over the stars of the new pattern.
// Stalls: s_tready follows m_tready whenever a verdict is waiting.
module wildcard_name_matcher (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] name_char
    input  logic                          s_tlast,   // end_of_name
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [0] matched, [7:1] zero
    output logic                          m_tlast,   // name_done
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wnm_pkg::ADDR_W-1:0]    paddr,
    input  logic [wnm_pkg::DATA_W-1:0]    pwdata,
    output logic [wnm_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import wnm_pkg::*;

    pattern_t           pattern;
    logic [POS_W-1:0]   pat_len;
    logic               cfg_wr;

    logic               refresh_reg;
    logic               accept;
    logic [7:0]         name_fold;
    ctrl_t              ctrl;

    link_t              link [NUM_POS+1];
    logic [NUM_POS-1:0] end_hit;
    logic [NUM_POS-1:0] active;
    logic [NUM_POS-1:0] at_end;
    logic               matched;

    logic               m_valid_reg;
    logic               m_valid_next;
    logic               m_match_reg;
    logic               m_last_reg;

    wnm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pattern (pattern),
        .pat_len (pat_len),
        .cfg_wr  (cfg_wr)
    );

    // Hold off input while the live bits are being re-closed; otherwise accept
    // whenever the result register is empty or draining this cycle.
    assign s_tready  = ~refresh_reg & (~m_valid_reg | m_tready);
    assign accept    = s_tvalid & s_tready;
    assign name_fold = fold_case(s_tdata);

    assign ctrl.refresh = refresh_reg;
    assign ctrl.accept  = accept;
    assign ctrl.last    = s_tlast;

    // Re-close once after reset and once after every register write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            refresh_reg <= 1'b1;
        end else begin
            refresh_reg <= cfg_wr;
        end
    end

    assign link[0] = '0;

    for (genvar i = 0; i < NUM_POS; i++) begin : g_cell
        assign active[i] = (POS_W'(i) < pat_len);
        assign at_end[i] = (POS_W'(i) == pat_len);

        wnm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .name_fold (name_fold),
            .pat_char  (pattern[i]),
            .active    (active[i]),
            .at_end    (at_end[i]),
            .is_first  ((i == 0) ? 1'b1 : 1'b0),
            .link_in   (link[i]),
            .link_out  (link[i+1]),
            .end_hit   (end_hit[i])
        );
    end

    // Only the cell at the pattern's end can report a full match.
    assign matched = |end_hit;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload needs no reset: load on every accepted request.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_match_reg <= matched;
            m_last_reg  <= s_tlast;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_match_reg};
    assign m_tlast  = m_last_reg;

endmodule

// File: rtl/core/wnm_cfg.sv
// Configuration register file of the wildcard name matcher.
module wnm_cfg (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [wnm_pkg::ADDR_W-1:0] paddr,
    input  logic [wnm_pkg::DATA_W-1:0] pwdata,
    output logic [wnm_pkg::DATA_W-1:0] prdata,
    output logic                   pready,
    output wnm_pkg::pattern_t      pattern,
    output logic [wnm_pkg::POS_W-1:0] pat_len,
    output logic                   cfg_wr
);
    import wnm_pkg::*;

    logic [DATA_W-1:0]    word_reg [NUM_WORDS];
    logic [POS_W-1:0]     len_reg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:3];
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg_wr = wr_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg[0] <= DATA_W'(CHAR_STAR);
            word_reg[1] <= '0;
            word_reg[2] <= '0;
            word_reg[3] <= '0;
            len_reg     <= POS_W'(1);
        end else if (wr_en) begin
            case (idx)
                REG_PAT_LOW:      word_reg[0] <= pwdata;
                REG_PAT_MID_LOW:  word_reg[1] <= pwdata;
                REG_PAT_MID_HIGH: word_reg[2] <= pwdata;
                REG_PAT_HIGH:     word_reg[3] <= pwdata;
                REG_LENGTH:       len_reg     <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PAT_LOW:      prdata = word_reg[0];
            REG_PAT_MID_LOW:  prdata = word_reg[1];
            REG_PAT_MID_HIGH: prdata = word_reg[2];
            REG_PAT_HIGH:     prdata = word_reg[3];
            REG_LENGTH:       prdata = DATA_W'(len_reg);
            default:          prdata = '0;
        endcase
    end

    assign pattern = pattern_t'({word_reg[3], word_reg[2], word_reg[1], word_reg[0]});
    // Length field is 5 bits, so it never exceeds the 31-position maximum.
    assign pat_len = len_reg;

endmodule

// File: rtl/core/wnm_cell.sv
// One pattern position: its live bit, its match test and its star-closure link.
module wnm_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  wnm_pkg::ctrl_t  ctrl,
    input  logic [7:0]      name_fold,
    input  logic [7:0]      pat_char,
    input  logic            active,
    input  logic            at_end,
    input  logic            is_first,
    input  wnm_pkg::link_t  link_in,
    output wnm_pkg::link_t  link_out,
    output logic            end_hit
);
    import wnm_pkg::*;

    logic raw_reg;
    logic raw_next;
    logic live_reg;
    logic live_next;
    logic star;
    logic any_char;
    logic keep;
    logic stay;
    logic nxt;
    logic start;
    logic refr;

    assign star     = (pat_char == CHAR_STAR);
    assign any_char = (pat_char == CHAR_ANY);
    assign keep     = active | at_end;

    // raw_reg holds the bit as left by the last request (a fresh name holds only
    // position zero); live_reg is raw_reg closed over stars under the current
    // pattern. Re-close from raw_reg so bits reached only through an older
    // pattern's stars drop out.
    assign stay  = live_reg & active & star;
    assign nxt   = stay | link_in.hit | link_in.step;
    assign start = is_first | link_in.start;
    assign refr  = (raw_reg & keep) | link_in.refresh;

    assign link_out.hit     = live_reg & active & ~star
                              & (any_char | (fold_case(pat_char) == name_fold));
    assign link_out.step    = nxt & active & star;
    assign link_out.start   = start & active & star;
    assign link_out.refresh = refr & active & star;

    assign end_hit = nxt & at_end;

    always_comb begin
        raw_next  = raw_reg;
        live_next = live_reg;
        if (ctrl.refresh) begin
            live_next = refr;
        end else if (ctrl.accept) begin
            raw_next  = ctrl.last ? is_first : nxt;
            live_next = ctrl.last ? start : nxt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg  <= is_first;
            live_reg <= is_first;
        end else begin
            raw_reg  <= raw_next;
            live_reg <= live_next;
        end
    end

endmodule
